// ===== design/bphd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the two-button press/hold dimmer.
// Used by bphd_btn_update and button_press_hold_dimmer; depends on nothing.
package bphd_pkg;

    // Timing thresholds in milliseconds.
    localparam logic [31:0] DEBOUNCE_MS = 32'd20;
    localparam logic [31:0] HOLD_MS     = 32'd500;
    localparam logic [31:0] RAMP_MS     = 32'd30;
    localparam logic [31:0] SWITCH_MS   = 32'd50;

    // Brightness ramp constants.
    localparam logic [7:0] RAMP_STEP      = 8'd5;
    localparam logic [7:0] RAMP_LOW_EDGE  = 8'd5;
    localparam logic [7:0] RAMP_HIGH_EDGE = 8'd250;
    localparam logic [7:0] BRIGHT_MAX     = 8'd255;

    // Stream payload widths.
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FIRST_ENABLED  = 2'd0,
        CFG_FIRST_IS_PUSH  = 2'd1,
        CFG_SECOND_ENABLED = 2'd2,
        CFG_SECOND_IS_PUSH = 2'd3
    } t_cfg_idx;

    // Per-button state.
    typedef struct packed {
        logic        stable_level;
        logic [31:0] press_stamp;
        logic        press_consumed;
        logic        ramp_downward;
        logic [31:0] last_ramp_stamp;
        logic [31:0] edge_stamp;
    } t_btn_state;

    localparam t_btn_state BTN_STATE_RESET = '{
        stable_level:    1'b1,
        press_stamp:     32'd0,
        press_consumed:  1'b0,
        ramp_downward:   1'b0,
        last_ramp_stamp: 32'd0,
        edge_stamp:      32'd0
    };

    // One result item.
    typedef struct packed {
        logic       power_write;
        logic       power_value;
        logic       brightness_write;
        logic [7:0] brightness_value;
    } t_result;

endpackage

// ===== design/bphd_btn_update.sv =====
`timescale 1ns / 1ps
// Combinational update of one button's state for one pin sample.
// Depends on bphd_pkg for the state and result types and the thresholds.
module bphd_btn_update (
    input  logic                 i_enabled,
    input  logic                 i_is_push,
    input  logic                 i_level,
    input  logic [31:0]          i_now,
    input  logic                 i_power,
    input  logic [7:0]           i_bright,
    input  bphd_pkg::t_btn_state i_state,
    output bphd_pkg::t_btn_state o_state,
    output bphd_pkg::t_result    o_result
);

    logic [31:0] since_edge;
    logic [31:0] since_press;
    logic [31:0] since_ramp;
    logic        level_change;
    logic        push_edge;
    logic        switch_edge;
    logic        ramp_due;

    assign since_edge   = i_now - i_state.edge_stamp;
    assign since_press  = i_now - i_state.press_stamp;
    assign since_ramp   = i_now - i_state.last_ramp_stamp;
    assign level_change = (i_level != i_state.stable_level);
    assign push_edge    = level_change && (since_edge > bphd_pkg::DEBOUNCE_MS);
    assign switch_edge  = level_change && (since_press > bphd_pkg::SWITCH_MS);

    // A ramp step can only happen on a sample that is not an accepted edge:
    // a press edge restarts the hold time and a release edge ends the hold.
    assign ramp_due = !push_edge && !i_state.stable_level && !i_state.press_consumed &&
                      (since_press > bphd_pkg::HOLD_MS) && (since_ramp > bphd_pkg::RAMP_MS);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_enabled) begin
            if (i_is_push) begin
                if (push_edge) begin
                    o_state.edge_stamp   = i_now;
                    o_state.stable_level = i_level;
                    if (!i_level) begin
                        o_state.press_stamp    = i_now;
                        o_state.press_consumed = 1'b0;
                    end else begin
                        if (!i_state.press_consumed && (since_press > bphd_pkg::DEBOUNCE_MS) &&
                            (since_press < bphd_pkg::HOLD_MS)) begin
                            o_result.power_write = 1'b1;
                            o_result.power_value = ~i_power;
                        end
                        if (since_press >= bphd_pkg::HOLD_MS) begin
                            o_state.ramp_downward = ~i_state.ramp_downward;
                        end
                        o_state.press_consumed = 1'b1;
                    end
                end
                if (ramp_due) begin
                    o_state.last_ramp_stamp   = i_now;
                    o_result.brightness_write = 1'b1;
                    if (i_state.ramp_downward) begin
                        if (i_bright > bphd_pkg::RAMP_LOW_EDGE) begin
                            o_result.brightness_value = i_bright - bphd_pkg::RAMP_STEP;
                        end else begin
                            o_result.brightness_value = 8'd0;
                            o_state.ramp_downward     = 1'b0;
                        end
                    end else begin
                        if (i_bright < bphd_pkg::RAMP_HIGH_EDGE) begin
                            o_result.brightness_value = i_bright + bphd_pkg::RAMP_STEP;
                        end else begin
                            o_result.brightness_value = bphd_pkg::BRIGHT_MAX;
                            o_state.ramp_downward     = 1'b1;
                        end
                    end
                end
            end else begin
                if (switch_edge) begin
                    o_state.press_stamp  = i_now;
                    o_state.stable_level = i_level;
                    o_result.power_write = 1'b1;
                    o_result.power_value = ~i_power;
                end
            end
        end
    end

endmodule

// ===== design/button_press_hold_dimmer.sv =====
`timescale 1ns / 1ps
// Top level of the two-button light controller with debounce, short press and hold-to-dim.
// Depends on bphd_pkg and instantiates bphd_btn_update.
//
//  Channel   Direction  Ports                          Beat contents
//  --------  ---------  -----------------------------  -------------------------------------
//  s_axis    in         s_axis_tvalid/tready/tdata/tuser  one pin sample of one button
//  m_axis    out        m_axis_tvalid/tready/tdata     one power/brightness command
//  cfg       in         i_cfg_valid/o_cfg_ready/...    one write of a 1-bit setup register
//
// Every accepted sample beat yields exactly one result beat. A beat moves from the input
// register to the result register, so the block takes one beat per cycle while m_axis
// does not stall, and each result is presented on m_axis straight from the output of
// the result register. The per-button state lives in flip-flops and is updated in the same
// cycle the sample is evaluated, so a sample of the same button in the very next cycle
// already sees the new state. Stalls on m_axis hold the result register and then the input
// register; s_axis_tready drops only when both are full and m_axis_tready is low.
// Reset (synchronous, active low) clears the handshake state, disables both buttons, sets
// the first to push and the second to switch, and stores every button as released with all stamps zero.
module button_press_hold_dimmer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // Sample stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata, from bit 0: pin_level[0], now_ms[32:1], power_now[33], brightness_now[41:34],
    // zero fill [47:42].
    input  logic [bphd_pkg::S_DATA_W-1:0] s_axis_tdata,
    // tuser: button_index[0].
    input  logic [0:0]                    s_axis_tuser,

    // Result stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata, from bit 0: power_write[0], power_value[1], brightness_write[2],
    // brightness_value[10:3], zero fill [15:11].
    output logic [bphd_pkg::M_DATA_W-1:0] m_axis_tdata,

    // Setup register writes.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic                          i_cfg_data
);

    // Setup registers.
    logic r_first_enabled;
    logic r_first_is_push;
    logic r_second_enabled;
    logic r_second_is_push;

    // Input register.
    logic                          r_in_valid;
    logic                          r_in_button;
    logic [bphd_pkg::S_DATA_W-1:0] r_in_data;

    // Result register.
    logic              r_out_valid;
    bphd_pkg::t_result r_out_result;

    // Button state, one entry per button.
    bphd_pkg::t_btn_state [1:0] r_btn;

    logic                 advance;
    logic                 sel_enabled;
    logic                 sel_is_push;
    bphd_pkg::t_btn_state sel_state;
    bphd_pkg::t_btn_state n_state;
    bphd_pkg::t_result    n_result;

    // The result register can load whenever it is empty or being drained.
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign sel_enabled = r_in_button ? r_second_enabled : r_first_enabled;
    assign sel_is_push = r_in_button ? r_second_is_push : r_first_is_push;
    assign sel_state   = r_btn[r_in_button];

    bphd_btn_update u_update (
        .i_enabled (sel_enabled),
        .i_is_push (sel_is_push),
        .i_level   (r_in_data[0]),
        .i_now     (r_in_data[32:1]),
        .i_power   (r_in_data[33]),
        .i_bright  (r_in_data[41:34]),
        .i_state   (sel_state),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // Setup register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_enabled  <= 1'b0;
            r_first_is_push  <= 1'b1;
            r_second_enabled <= 1'b0;
            r_second_is_push <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (bphd_pkg::t_cfg_idx'(i_cfg_index))
                bphd_pkg::CFG_FIRST_ENABLED:  r_first_enabled  <= i_cfg_data;
                bphd_pkg::CFG_FIRST_IS_PUSH:  r_first_is_push  <= i_cfg_data;
                bphd_pkg::CFG_SECOND_ENABLED: r_second_enabled <= i_cfg_data;
                bphd_pkg::CFG_SECOND_IS_PUSH: r_second_is_push <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_button <= s_axis_tuser[0];
            r_in_data   <= s_axis_tdata;
        end
    end

    // Result register control and button state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_btn[0]    <= bphd_pkg::BTN_STATE_RESET;
            r_btn[1]    <= bphd_pkg::BTN_STATE_RESET;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_btn[r_in_button] <= n_state;
            end
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(bphd_pkg::M_DATA_W - 11){1'b0}},
                            r_out_result.brightness_value,
                            r_out_result.brightness_write,
                            r_out_result.power_value,
                            r_out_result.power_write};

`ifndef SYNTHESIS
    // A power toggle comes only on an edge, a ramp step only away from one.
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_result.power_write && r_out_result.brightness_write))
        else $error("power and brightness written by the same beat");

    // Values that are not written are zero.
    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_result.power_write || !r_out_result.power_value) &&
                         (r_out_result.brightness_write ||
                          r_out_result.brightness_value == 8'd0)))
        else $error("unwritten result value is not zero");

    // A sample held back by a stalled result register is not lost.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("pending sample dropped during stall");

    // A disabled button leaves all button state untouched.
    a_disabled_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && !sel_enabled) |=> $stable(r_btn))
        else $error("disabled button changed state");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the two-button press/hold dimmer.
// Depends on bphd_pkg and button_press_hold_dimmer; needs no files or arguments.
module tb_top;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 300000;
    // Receiver hold-off that backs the block up until it stalls its sample input.
    localparam int PRESSURE_CYCLES = 400;
    // Random samples per phase that reach an enabled button.
    localparam int PHASE_ITEMS = 300;

    // Scoreboard: mirrors the setup registers and the per-button state, works out the
    // light command that each accepted sample must produce and checks result beats
    // against those commands in order.
    class dimmer_scoreboard;
        bphd_pkg::t_btn_state btn_state [2];
        logic                 enabled [2];
        logic                 is_push [2];
        bphd_pkg::t_result    pending_cmds [$];
        int                   mismatches;

        function new();
            for (int i = 0; i < 2; i++) begin
                btn_state[i] = bphd_pkg::BTN_STATE_RESET;
            end
            enabled[0]  = 1'b0;
            is_push[0]  = 1'b1;
            enabled[1]  = 1'b0;
            is_push[1]  = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_reg(bphd_pkg::t_cfg_idx idx, logic value);
            case (idx)
                bphd_pkg::CFG_FIRST_ENABLED: begin
                    enabled[0] = value;
                end
                bphd_pkg::CFG_FIRST_IS_PUSH: begin
                    is_push[0] = value;
                end
                bphd_pkg::CFG_SECOND_ENABLED: begin
                    enabled[1] = value;
                end
                bphd_pkg::CFG_SECOND_IS_PUSH: begin
                    is_push[1] = value;
                end
                default: begin
                end
            endcase
        endfunction

        // Updates the button's state for one accepted sample and queues the command.
        function bphd_pkg::t_result note_sample(logic b, logic level, logic [31:0] now,
                                                logic power, logic [7:0] bri);
            bphd_pkg::t_btn_state st;
            bphd_pkg::t_result    cmd;
            logic [31:0]          held;
            int                   idx;
            idx = b;
            st  = btn_state[idx];
            cmd = '0;
            if (enabled[idx] && is_push[idx]) begin
                // Debounced level change of a push button.
                if (level != st.stable_level &&
                    (now - st.edge_stamp) > bphd_pkg::DEBOUNCE_MS) begin
                    st.edge_stamp   = now;
                    st.stable_level = level;
                    if (!level) begin
                        st.press_stamp    = now;
                        st.press_consumed = 1'b0;
                    end else begin
                        held = now - st.press_stamp;
                        if (!st.press_consumed && held > bphd_pkg::DEBOUNCE_MS &&
                            held < bphd_pkg::HOLD_MS) begin
                            cmd.power_write = 1'b1;
                            cmd.power_value = ~power;
                        end
                        // A release after a long hold reverses the ramp.
                        if (held >= bphd_pkg::HOLD_MS) begin
                            st.ramp_downward = ~st.ramp_downward;
                        end
                        st.press_consumed = 1'b1;
                    end
                end
                // Held down: one ramp step per ramp interval, bouncing off the ends.
                if (!st.stable_level && !st.press_consumed &&
                    (now - st.press_stamp) > bphd_pkg::HOLD_MS &&
                    (now - st.last_ramp_stamp) > bphd_pkg::RAMP_MS) begin
                    st.last_ramp_stamp   = now;
                    cmd.brightness_write = 1'b1;
                    if (st.ramp_downward) begin
                        if (bri > bphd_pkg::RAMP_LOW_EDGE) begin
                            cmd.brightness_value = bri - bphd_pkg::RAMP_STEP;
                        end else begin
                            cmd.brightness_value = '0;
                            st.ramp_downward     = 1'b0;
                        end
                    end else begin
                        if (bri < bphd_pkg::RAMP_HIGH_EDGE) begin
                            cmd.brightness_value = bri + bphd_pkg::RAMP_STEP;
                        end else begin
                            cmd.brightness_value = bphd_pkg::BRIGHT_MAX;
                            st.ramp_downward     = 1'b1;
                        end
                    end
                end
            end else if (enabled[idx]) begin
                // A switch toggles power on any change after its lockout.
                if (level != st.stable_level &&
                    (now - st.press_stamp) > bphd_pkg::SWITCH_MS) begin
                    st.press_stamp  = now;
                    st.stable_level = level;
                    cmd.power_write = 1'b1;
                    cmd.power_value = ~power;
                end
            end
            btn_state[idx] = st;
            pending_cmds.push_back(cmd);
            return cmd;
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                mismatches++;
                $error("%s: expected %0d, actual %0d", field, want, got);
            end
        endfunction

        function void check_command(logic [bphd_pkg::M_DATA_W-1:0] beat);
            bphd_pkg::t_result want;
            if (pending_cmds.size() == 0) begin
                mismatches++;
                $error("result beat %h arrived with no sample waiting for it", beat);
                return;
            end
            want = pending_cmds.pop_front();
            compare("power_write", want.power_write, beat[0]);
            compare("power_value", want.power_value, beat[1]);
            compare("brightness_write", want.brightness_write, beat[2]);
            compare("brightness_value", want.brightness_value, beat[10:3]);
            compare("zero_fill", '0, beat[15:11]);
        endfunction
    endclass

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [bphd_pkg::S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [0:0]                    s_axis_tuser  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [bphd_pkg::M_DATA_W-1:0] m_axis_tdata;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [1:0]                    i_cfg_index   = bphd_pkg::CFG_FIRST_ENABLED;
    logic                          i_cfg_data    = 1'b0;

    dimmer_scoreboard sb = new();

    // Idling controls, set by the stimulus process for each phase.
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    bit pressure_req  = 1'b0;

    // Receiver-side bookkeeping, owned by the result process; the cycle count is the watchdog's.
    bit pressure_done = 1'b0;
    int hold_left     = 0;
    int cycle_count   = 0;

    // Stimulus-side model of the lamp: the power and brightness that the commands so far
    // would have left behind, so ramps and toggles feed back like in a real fixture.
    logic        light_power = 1'b0;
    logic [7:0]  light_bri   = 8'd128;
    logic [31:0] t_now       = '0;
    int          useful_count = 0;

    button_press_hold_dimmer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: check each accepted beat, then pick the next tready. A pressure request
    // holds tready low for a long stretch once, so the block fills and stalls its input.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            sb.check_command(m_axis_tdata);
        end
        if (pressure_req && !pressure_done) begin
            pressure_done = 1'b1;
            hold_left     = PRESSURE_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offers one sample beat and waits until it is accepted. tvalid is left high so a
    // following beat can go out back to back; callers lower it when the stream pauses.
    task automatic send_sample(logic b, logic level, logic [31:0] now, logic power,
                               logic [7:0] bri);
        bphd_pkg::t_result cmd;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= b;
        s_axis_tdata  <= {6'b0, bri, power, now, level};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        if (sb.enabled[b]) begin
            useful_count++;
        end
        cmd = sb.note_sample(b, level, now, power, bri);
        if (cmd.power_write) begin
            light_power = cmd.power_value;
        end
        if (cmd.brightness_write) begin
            light_bri = cmd.brightness_value;
        end
    endtask

    // A sample at the current time with the lamp's state, now and then disturbed so that
    // brightness and power also take values the commands would not lead to.
    task automatic offer(logic b, logic level);
        if ($urandom_range(19) == 0) begin
            light_bri = 8'($urandom_range(255));
        end
        if ($urandom_range(19) == 0) begin
            light_power = ~light_power;
        end
        send_sample(b, level, t_now, light_power, light_bri);
    endtask

    task automatic write_reg(bphd_pkg::t_cfg_idx idx, logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        sb.write_reg(idx, value);
    endtask

    // Setup writes go in only once every command has come back and the block has settled.
    task automatic set_config(logic e0, logic p0, logic e1, logic p1);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_cmds.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        write_reg(bphd_pkg::CFG_FIRST_ENABLED, e0);
        write_reg(bphd_pkg::CFG_FIRST_IS_PUSH, p0);
        write_reg(bphd_pkg::CFG_SECOND_ENABLED, e1);
        write_reg(bphd_pkg::CFG_SECOND_IS_PUSH, p1);
        i_cfg_valid <= 1'b0;
    endtask

    // One press of a push button: press, optional contact bounce, samples while held,
    // release and optional release bounce. Hold times cover short presses, the exact
    // hold threshold, long ramping holds and presses too short to count.
    task automatic push_gesture(logic b);
        logic [31:0] press_t;
        logic [31:0] hold;
        int          kind;
        kind = $urandom_range(9);
        if (kind <= 3) begin
            hold = $urandom_range(21, 499);
        end else if (kind == 4) begin
            hold = bphd_pkg::HOLD_MS;
        end else if (kind <= 7) begin
            hold = $urandom_range(501, 2500);
        end else begin
            hold = $urandom_range(1, 20);
        end
        t_now += $urandom_range(0, 300);
        offer(b, 1'b0);
        press_t = t_now;
        if ($urandom_range(2) == 0) begin
            t_now += $urandom_range(1, 10);
            offer(b, 1'b1);
        end
        while (t_now - press_t + 40 < hold) begin
            t_now += $urandom_range(5, 40);
            // The other button chatters now and then in the middle of a hold.
            if ($urandom_range(9) == 0) begin
                offer(~b, 1'($urandom_range(1)));
            end else begin
                offer(b, 1'b0);
            end
        end
        t_now = press_t + hold;
        offer(b, 1'b1);
        if ($urandom_range(3) == 0) begin
            t_now += $urandom_range(1, 20);
            offer(b, 1'b0);
            t_now += $urandom_range(1, 5);
            offer(b, 1'b1);
        end
    endtask

    // A switch mostly changes position, sometimes inside its lockout window.
    task automatic switch_gesture(logic b);
        logic level;
        t_now += $urandom_range(0, 150);
        level = ($urandom_range(9) < 7) ? ~sb.btn_state[b].stable_level
                                        : sb.btn_state[b].stable_level;
        offer(b, level);
    endtask

    // Random part of one phase; needs at least one button enabled.
    task automatic run_phase(int target);
        int  stop_at;
        logic b;
        stop_at = useful_count + target;
        while (useful_count < stop_at) begin
            if (sb.enabled[0] && sb.enabled[1]) begin
                b = 1'($urandom_range(1));
            end else if (sb.enabled[0]) begin
                b = ($urandom_range(9) == 0);
            end else begin
                b = ($urandom_range(9) != 0);
            end
            if ($urandom_range(49) == 0) begin
                // Wild jump in time, so every timestamp bit toggles.
                t_now = $urandom();
                offer(b, 1'($urandom_range(1)));
            end else if (!sb.enabled[b]) begin
                offer(b, 1'($urandom_range(1)));
            end else if (sb.is_push[b]) begin
                push_gesture(b);
            end else begin
                switch_gesture(b);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Both buttons come out of reset disabled: these produce all-zero commands.
        send_sample(1'b0, 1'b1, 32'd50, 1'b0, 8'd128);
        send_sample(1'b1, 1'b0, 32'd60, 1'b1, 8'd0);

        set_config(1'b1, 1'b1, 1'b1, 1'b0);
        // A released sample on a fresh push button is no edge: the stored level starts
        // released.
        send_sample(1'b0, 1'b1, 32'd70, light_power, light_bri);
        // Press, bounce inside the debounce window, short press toggles on release.
        send_sample(1'b0, 1'b0, 32'd100, light_power, light_bri);
        send_sample(1'b0, 1'b1, 32'd110, light_power, light_bri);
        send_sample(1'b0, 1'b1, 32'd300, light_power, light_bri);
        // Press of exactly the hold time: no toggle, ramp direction flips to downward.
        send_sample(1'b0, 1'b0, 32'd1000, light_power, light_bri);
        send_sample(1'b0, 1'b1, 32'd1500, light_power, light_bri);
        // Release right at the debounce limit is ignored, one ms later it toggles.
        send_sample(1'b0, 1'b0, 32'd2000, light_power, light_bri);
        send_sample(1'b0, 1'b1, 32'd2020, light_power, light_bri);
        send_sample(1'b0, 1'b1, 32'd2021, light_power, light_bri);
        // Long hold: ramp hits the low end, turns, hits the high end, turns again.
        send_sample(1'b0, 1'b0, 32'd3000, light_power, light_bri);
        send_sample(1'b0, 1'b0, 32'd3501, light_power, 8'd3);
        send_sample(1'b0, 1'b0, 32'd3532, light_power, 8'd252);
        send_sample(1'b0, 1'b0, 32'd3540, light_power, 8'd255);
        send_sample(1'b0, 1'b0, 32'd3600, light_power, 8'd6);
        send_sample(1'b0, 1'b1, 32'd4000, light_power, light_bri);
        // Switch on button two: toggle, change inside the lockout, toggle.
        send_sample(1'b1, 1'b0, 32'd4100, light_power, light_bri);
        send_sample(1'b1, 1'b1, 32'd4130, light_power, light_bri);
        send_sample(1'b1, 1'b1, 32'd4151, light_power, light_bri);
        // Field extremes and a lockout measured across the timestamp wrap.
        send_sample(1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1, 8'd255);
        send_sample(1'b1, 1'b1, 32'h0000_0031, 1'b0, 8'd0);
        send_sample(1'b1, 1'b1, 32'h0000_0032, 1'b1, 8'd255);

        // Random phases, each with its own setup and idling pattern.
        t_now = 32'd5000;
        run_phase(PHASE_ITEMS);

        set_config(1'b1, 1'b1, 1'b1, 1'b1);
        tx_idle_pct = 76;
        run_phase(PHASE_ITEMS);

        set_config(1'b1, 1'b0, 1'b1, 1'b0);
        tx_idle_pct  = 0;
        rx_stall_pct = 76;
        run_phase(PHASE_ITEMS);

        // Nothing enabled: every sample is ignored.
        set_config(1'b0, 1'b0, 1'b0, 1'b0);
        rx_stall_pct = 0;
        repeat (20) begin
            t_now += $urandom_range(0, 100);
            offer(1'($urandom_range(1)), 1'($urandom_range(1)));
        end

        // Run across the timestamp wrap with sparse idling on both sides.
        set_config(1'b0, 1'b0, 1'b1, 1'b1);
        tx_idle_pct  = 6;
        rx_stall_pct = 6;
        t_now        = 32'hFFFF_F800;
        run_phase(PHASE_ITEMS);

        set_config(1'b1, 1'b1, 1'b0, 1'b0);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        pressure_req = 1'b1;
        run_phase(PHASE_ITEMS);

        set_config(1'b1, 1'b0, 1'b1, 1'b1);
        tx_idle_pct  = 6;
        rx_stall_pct = 6;
        run_phase(PHASE_ITEMS);

        // Drain: every command back, then a short wait for anything stray.
        s_axis_tvalid <= 1'b0;
        while (sb.pending_cmds.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/bphd_pkg.sv
design/bphd_btn_update.sv
design/button_press_hold_dimmer.sv
test/tb_top.sv
